>>> sv/efc_pkg.sv
// Shared types and constants for the elevator floor controller.
// Used by elevator_floor_controller; depends on nothing else.
package efc_pkg;

  localparam int unsigned FLOORS    = 4;
  localparam int unsigned DOOR_W    = 10;
  localparam int unsigned TRAVEL_W  = 10;
  localparam int unsigned HOLD_W    = 7;
  localparam int unsigned CFG_W     = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PASSES    = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_DOOR_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS   = 2'd2;

  localparam logic [DOOR_W-1:0]   DOOR_TICKS_RST   = 10'd201;
  localparam logic [TRAVEL_W-1:0] TRAVEL_TICKS_RST = 10'd601;
  localparam logic [HOLD_W-1:0]   HOLD_TICKS_RST   = 7'd110;

  localparam logic CMD_KEY = 1'b1;

  typedef enum logic [1:0] {
    MOTOR_STOP = 2'd0,
    MOTOR_UP   = 2'd1,
    MOTOR_DOWN = 2'd2
  } motor_e;

  typedef enum logic [1:0] {
    DOOR_IDLE    = 2'd0,
    DOOR_OPENING = 2'd1,
    DOOR_CLOSING = 2'd2
  } door_e;

  typedef struct packed {
    logic [FLOORS-1:0]   requests;
    logic [FLOORS-1:0]   floor_oh;
    logic                door_is_open;
    logic [DOOR_W-1:0]   door_tmr;
    logic [TRAVEL_W-1:0] travel_tmr;
    logic [HOLD_W-1:0]   hold_tmr;
    motor_e              motor;
    door_e               door_mot;
  } ctl_t;

endpackage

>>> sv/elevator_floor_controller.sv
// Elevator floor controller: request mask, hold countdown and service rule.
// Depends on efc_pkg.
//
// Usage: each input item is either one timer tick (cmd 0) or one floor key
// press (cmd 1, key_floor zero based). Every accepted item yields exactly one
// result item carrying the floor, request mask, motor and door drives, door
// state, an arrival pulse and the serving flag after that item.
// Each result is registered and is valid right after the edge that accepts its
// item. Throughput is one item per cycle while the receiver takes results; the
// next state and all up to three service passes are worked out in one
// combinational step from the state registers.
// The result register frees as it is taken, so input ready stays high while
// the receiver takes results. When the receiver stalls, the result holds and
// input ready drops until it is taken.
// Configuration writes (door, travel and hold ticks) take effect at once.
// Reset puts the cage at floor 1 with the door open, no requests, all timers
// and drives at zero, and the tick registers at 201, 601 and 110.
module elevator_floor_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [efc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [efc_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cmd_i,
  input  logic [1:0]                     key_floor_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [2:0]                     floor_now_o,
  output logic [3:0]                     request_mask_o,
  output logic [1:0]                     motor_drive_o,
  output logic [1:0]                     door_drive_o,
  output logic                           door_is_open_o,
  output logic                           arrived_o,
  output logic                           serving_o
);
  import efc_pkg::*;

  logic [DOOR_W-1:0]   door_ticks_q;
  logic [TRAVEL_W-1:0] travel_ticks_q;
  logic [HOLD_W-1:0]   hold_ticks_q;

  ctl_t ctl_q, ctl_d;
  logic arrive_d;

  logic       out_valid_q;
  logic [2:0] floor_now_q, floor_now_d;
  logic [3:0] request_mask_q;
  logic [1:0] motor_drive_q, door_drive_q;
  logic       door_is_open_q, arrived_q, serving_q;

  logic accept;

  function automatic ctl_t serve_pass(input ctl_t s, input logic [DOOR_W-1:0] dtk,
                                      input logic [TRAVEL_W-1:0] ttk,
                                      inout logic arrive);
    ctl_t r;
    logic up;
    logic [FLOORS-1:0] moved;
    r = s;
    up = (s.requests > s.floor_oh);
    moved = up ? (s.floor_oh << 1) : (s.floor_oh >> 1);
    if (s.requests == '0) begin
      r.hold_tmr = '0;
    end else if ((s.requests & s.floor_oh) != '0) begin
      if (!s.door_is_open) begin
        if (r.door_tmr == '0) begin
          r.motor    = MOTOR_STOP;
          r.door_mot = DOOR_OPENING;
          r.door_tmr = dtk;
        end
        if (r.door_tmr == DOOR_W'(1)) begin
          r.door_is_open = 1'b1;
          r.door_tmr     = '0;
          r.door_mot     = DOOR_IDLE;
        end
      end else begin
        if (r.travel_tmr == '0) begin
          r.travel_tmr = TRAVEL_W'(dtk);
        end
        if (r.travel_tmr == TRAVEL_W'(1)) begin
          r.travel_tmr = '0;
          r.requests   = s.requests ^ s.floor_oh;
          arrive       = 1'b1;
          if (r.requests == '0) begin
            r.hold_tmr = '0;
          end
        end
      end
    end else begin
      if (s.door_is_open) begin
        if (r.door_tmr == '0) begin
          r.door_mot = DOOR_CLOSING;
          r.door_tmr = dtk;
        end
        if (r.door_tmr == DOOR_W'(1)) begin
          r.door_is_open = 1'b0;
          r.door_tmr     = '0;
          r.door_mot     = DOOR_IDLE;
        end
      end else begin
        if (r.travel_tmr == '0) begin
          r.motor      = up ? MOTOR_UP : MOTOR_DOWN;
          r.travel_tmr = ttk;
        end
        if (r.travel_tmr == TRAVEL_W'(1)) begin
          r.travel_tmr = '0;
          r.floor_oh   = (moved == '0) ? s.floor_oh : moved;
        end
      end
    end
    return r;
  endfunction

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;

  always_comb begin
    ctl_d    = ctl_q;
    arrive_d = 1'b0;
    if (cmd_i == CMD_KEY) begin
      if (ctl_q.hold_tmr != HOLD_W'(1)) begin
        ctl_d.requests = ctl_q.requests | (FLOORS'(1) << key_floor_i);
        ctl_d.hold_tmr = hold_ticks_q;
      end
    end else begin
      if (ctl_q.hold_tmr > HOLD_W'(1)) begin
        ctl_d.hold_tmr = ctl_q.hold_tmr - HOLD_W'(1);
      end
      if (ctl_q.travel_tmr > TRAVEL_W'(1)) begin
        ctl_d.travel_tmr = ctl_q.travel_tmr - TRAVEL_W'(1);
      end
      if (ctl_q.door_tmr > DOOR_W'(1)) begin
        ctl_d.door_tmr = ctl_q.door_tmr - DOOR_W'(1);
      end
      for (int p = 0; p < PASSES; p++) begin
        if (ctl_d.hold_tmr == HOLD_W'(1)) begin
          ctl_d = serve_pass(ctl_d, door_ticks_q, travel_ticks_q, arrive_d);
        end
      end
    end
  end

  always_comb begin
    floor_now_d = 3'(FLOORS);
    for (int i = FLOORS - 2; i >= 0; i--) begin
      if (ctl_d.floor_oh[i]) begin
        floor_now_d = 3'(i + 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      door_ticks_q   <= DOOR_TICKS_RST;
      travel_ticks_q <= TRAVEL_TICKS_RST;
      hold_ticks_q   <= HOLD_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DOOR_TICKS:   door_ticks_q   <= cfg_wdata_i[DOOR_W-1:0];
        CFG_TRAVEL_TICKS: travel_ticks_q <= cfg_wdata_i[TRAVEL_W-1:0];
        CFG_HOLD_TICKS:   hold_ticks_q   <= cfg_wdata_i[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q.requests     <= '0;
      ctl_q.floor_oh     <= FLOORS'(1);
      ctl_q.door_is_open <= 1'b1;
      ctl_q.door_tmr     <= '0;
      ctl_q.travel_tmr   <= '0;
      ctl_q.hold_tmr     <= '0;
      ctl_q.motor        <= MOTOR_STOP;
      ctl_q.door_mot     <= DOOR_IDLE;
      out_valid_q        <= 1'b0;
    end else begin
      if (accept) begin
        ctl_q <= ctl_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      floor_now_q    <= floor_now_d;
      request_mask_q <= 4'(ctl_d.requests);
      motor_drive_q  <= ctl_d.motor;
      door_drive_q   <= ctl_d.door_mot;
      door_is_open_q <= ctl_d.door_is_open;
      arrived_q      <= arrive_d;
      serving_q      <= (ctl_d.hold_tmr == HOLD_W'(1));
    end
  end

  assign out_valid_o    = out_valid_q;
  assign floor_now_o    = floor_now_q;
  assign request_mask_o = request_mask_q;
  assign motor_drive_o  = motor_drive_q;
  assign door_drive_o   = door_drive_q;
  assign door_is_open_o = door_is_open_q;
  assign arrived_o      = arrived_q;
  assign serving_o      = serving_q;

endmodule

>>> tb/elevator_floor_controller_tb.sv
// Testbench for elevator_floor_controller: directed and random items, checked
// against a cycle-free predictor of the lift's request, door and travel rules.
// Depends on efc_pkg and the elevator_floor_controller RTL.
module elevator_floor_controller_tb;
  import efc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SHOWN_MAX   = 10;
  localparam logic CMD_TICK  = ~CMD_KEY;

  typedef struct packed {
    logic [2:0]        floor_now;
    logic [FLOORS-1:0] req_mask;
    motor_e            motor;
    door_e             door;
    logic              door_is_open;
    logic              arrived;
    logic              serving;
  } lift_status_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = CFG_DOOR_TICKS;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 cmd_i       = 1'b0;
  logic [1:0]           key_floor_i = 2'd0;
  logic                 out_ready_i = 1'b0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic [2:0]           floor_now_o;
  logic [3:0]           request_mask_o;
  logic [1:0]           motor_drive_o;
  logic [1:0]           door_drive_o;
  logic                 door_is_open_o;
  logic                 arrived_o;
  logic                 serving_o;

  // Predicted lift state and register copies
  logic [DOOR_W-1:0]   door_ticks_q   = DOOR_TICKS_RST;
  logic [TRAVEL_W-1:0] travel_ticks_q = TRAVEL_TICKS_RST;
  logic [HOLD_W-1:0]   hold_ticks_q   = HOLD_TICKS_RST;
  logic [FLOORS-1:0]   lift_req       = '0;
  logic [FLOORS-1:0]   lift_floor_oh  = 4'b0001;
  logic                lift_door_is_open = 1'b1;
  logic [DOOR_W-1:0]   lift_door_tmr   = '0;
  logic [TRAVEL_W-1:0] lift_travel_tmr = '0;
  logic [HOLD_W-1:0]   lift_hold_tmr   = '0;
  motor_e              lift_motor     = MOTOR_STOP;
  door_e               lift_door_mot  = DOOR_IDLE;
  logic                lift_arrived   = 1'b0;

  lift_status_t status_q[$];
  bit idle_on    = 1'b1;
  int stall_left = 0;
  int errors     = 0;
  int items_sent = 0;
  int settings   = 0;
  int arrivals   = 0;
  int moves      = 0;
  int cycle_cnt  = 0;

  elevator_floor_controller u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .key_floor_i    (key_floor_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .floor_now_o    (floor_now_o),
    .request_mask_o (request_mask_o),
    .motor_drive_o  (motor_drive_o),
    .door_drive_o   (door_drive_o),
    .door_is_open_o (door_is_open_o),
    .arrived_o      (arrived_o),
    .serving_o      (serving_o)
  );

  always #10 clk_i = ~clk_i;

  task automatic serve_pass_once();
    logic [FLOORS-1:0] here;
    logic [FLOORS-1:0] pend;
    logic              up;
    here = lift_floor_oh;
    pend = lift_req;
    up   = pend > here;
    if (pend == '0) begin
      lift_hold_tmr = '0;
    end else if ((pend & here) != '0) begin
      if (!lift_door_is_open) begin
        if (lift_door_tmr == 0) begin
          lift_motor    = MOTOR_STOP;
          lift_door_mot = DOOR_OPENING;
          lift_door_tmr = door_ticks_q;
        end
        if (lift_door_tmr == 1) begin
          lift_door_is_open = 1'b1;
          lift_door_tmr     = '0;
          lift_door_mot     = DOOR_IDLE;
        end
      end else begin
        if (lift_travel_tmr == 0) lift_travel_tmr = door_ticks_q;
        if (lift_travel_tmr == 1) begin
          lift_travel_tmr = '0;
          lift_req        = lift_req ^ here;
          lift_arrived    = 1'b1;
          arrivals++;
          if (lift_req == '0) lift_hold_tmr = '0;
        end
      end
    end else if (lift_door_is_open) begin
      if (lift_door_tmr == 0) begin
        lift_door_mot = DOOR_CLOSING;
        lift_door_tmr = door_ticks_q;
      end
      if (lift_door_tmr == 1) begin
        lift_door_is_open = 1'b0;
        lift_door_tmr     = '0;
        lift_door_mot     = DOOR_IDLE;
      end
    end else begin
      if (lift_travel_tmr == 0) begin
        lift_motor      = up ? MOTOR_UP : MOTOR_DOWN;
        lift_travel_tmr = travel_ticks_q;
      end
      if (lift_travel_tmr == 1) begin
        lift_travel_tmr = '0;
        lift_floor_oh   = up ? here << 1 : here >> 1;
        if (lift_floor_oh == '0) lift_floor_oh = here;
        moves++;
      end
    end
  endtask

  task automatic step_lift(input logic cmd, input logic [1:0] key,
                           output lift_status_t st);
    int idx;
    lift_arrived = 1'b0;
    if (cmd == CMD_KEY) begin
      if (lift_hold_tmr != 1) begin
        lift_req[key] = 1'b1;
        lift_hold_tmr = hold_ticks_q;
      end
    end else begin
      if (lift_hold_tmr > 1) lift_hold_tmr--;
      if (lift_travel_tmr > 1) lift_travel_tmr--;
      if (lift_door_tmr > 1) lift_door_tmr--;
      for (int p = 0; p < PASSES && lift_hold_tmr == 1; p++) serve_pass_once();
    end
    idx = 0;
    while (idx < FLOORS - 1 && !lift_floor_oh[idx]) idx++;
    st.floor_now    = 3'(idx + 1);
    st.req_mask     = lift_req;
    st.motor        = lift_motor;
    st.door         = lift_door_mot;
    st.door_is_open = lift_door_is_open;
    st.arrived      = lift_arrived;
    st.serving      = (lift_hold_tmr == 1);
  endtask

  task automatic send_item(input logic cmd, input logic [1:0] key);
    lift_status_t st;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    key_floor_i <= key;
    do @(posedge clk_i); while (!in_ready_o);
    step_lift(cmd, key, st);
    status_q.push_back(st);
    items_sent++;
  endtask

  task automatic wait_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (status_q.size() != 0);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] door, input logic [CFG_W-1:0] travel,
                            input logic [CFG_W-1:0] hold);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_DOOR_TICKS;
    cfg_wdata_i <= door;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_TRAVEL_TICKS;
    cfg_wdata_i <= travel;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_HOLD_TICKS;
    cfg_wdata_i <= hold;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    door_ticks_q   = door;
    travel_ticks_q = travel;
    hold_ticks_q   = hold[HOLD_W-1:0];
    settings++;
  endtask

  task automatic check_status();
    lift_status_t got;
    lift_status_t want;
    got.floor_now    = floor_now_o;
    got.req_mask     = request_mask_o;
    got.motor        = motor_e'(motor_drive_o);
    got.door         = door_e'(door_drive_o);
    got.door_is_open = door_is_open_o;
    got.arrived      = arrived_o;
    got.serving      = serving_o;
    if (status_q.size() == 0) begin
      errors++;
      if (errors <= SHOWN_MAX)
        $display("result with none pending: floor=%0d mask=%h", floor_now_o, request_mask_o);
    end else begin
      want = status_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= SHOWN_MAX) begin
          $display("mismatch exp floor=%0d mask=%h motor=%0d door=%0d open=%b arr=%b srv=%b",
                   want.floor_now, want.req_mask, want.motor, want.door, want.door_is_open,
                   want.arrived, want.serving);
          $display("         got floor=%0d mask=%h motor=%0d door=%0d open=%b arr=%b srv=%b",
                   got.floor_now, got.req_mask, got.motor, got.door, got.door_is_open,
                   got.arrived, got.serving);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_status();
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 7);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_cnt, status_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Mostly key bursts, each followed by a tick run of random length
  task automatic run_traffic(input int n);
    int   count;
    int   span;
    logic cmd;
    count = 0;
    while (count < n) begin
      if ($urandom_range(0, 9) < 8) begin
        repeat ($urandom_range(1, 3)) begin
          if (lift_hold_tmr != 1) count++;
          send_item(CMD_KEY, 2'($urandom_range(0, 3)));
        end
        span = hold_ticks_q + 3 * door_ticks_q + 3 * travel_ticks_q + 10;
        if (span > 300) span = 300;
        repeat ($urandom_range(4, span)) begin
          send_item(CMD_TICK, 2'($urandom_range(0, 3)));
          count++;
        end
      end else begin
        cmd = 1'($urandom_range(0, 1));
        if (cmd == CMD_TICK || lift_hold_tmr != 1) count++;
        send_item(cmd, 2'($urandom_range(0, 3)));
      end
    end
    wait_results();
  endtask

  task automatic test_reset_defaults();
    for (int k = 0; k < FLOORS; k++) send_item(CMD_KEY, 2'(k));
    repeat (2) send_item(CMD_TICK, 2'd0);
    wait_results();
  endtask

  task automatic test_fast_timers();
    set_config(10'd1, 10'd1, 10'd1);
    send_item(CMD_KEY, 2'd2);
    send_item(CMD_KEY, 2'd1);
    repeat (5) send_item(CMD_TICK, 2'd3);
    wait_results();
  endtask

  task automatic test_zero_hold();
    set_config(10'd2, 10'd2, 10'd0);
    send_item(CMD_KEY, 2'd3);
    repeat (2) send_item(CMD_TICK, 2'd0);
    wait_results();
  endtask

  task automatic test_zero_door_travel();
    set_config(10'd0, 10'd0, 10'd2);
    send_item(CMD_KEY, 2'd0);
    repeat (3) send_item(CMD_TICK, 2'd1);
    wait_results();
  endtask

  task automatic test_min_settings();
    set_config(10'd2, 10'd2, 10'd2);
    run_traffic(120);
  endtask

  task automatic test_random_settings();
    repeat (5) begin
      set_config(10'($urandom_range(2, 8)), 10'($urandom_range(2, 12)),
                 {3'($urandom_range(0, 7)), 7'($urandom_range(2, 16))});
      run_traffic(130);
    end
  endtask

  task automatic test_max_settings();
    idle_on = 1'b0;
    set_config(10'd1023, 10'd1023, 10'd1023);
    run_traffic(150);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_fast_timers();
    test_zero_hold();
    test_zero_door_travel();
    test_min_settings();
    test_random_settings();
    test_max_settings();
    repeat (4) @(posedge clk_i);
    errors += status_q.size();
    $display("Sent %0d items over %0d register settings plus the reset values;", items_sent,
             settings);
    $display("the lift served %0d floors and moved %0d times, %0d errors.", arrivals, moves,
             errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
